/* sv/sip_puff_command_interpreter_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the sip/puff interpreter RTL
// ----------------------------------------------------------------------------
`ifndef SIP_PUFF_COMMAND_INTERPRETER_CORE_MACROS_SVH
`define SIP_PUFF_COMMAND_INTERPRETER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define SPPCI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define SPPCI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/sppci_pkg.sv */
// ----------------------------------------------------------------------------
// sppci_pkg
// Types, register indexes, reset values and word encoders for the
// sip/puff command interpreter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sppci_pkg;

    localparam int LEVEL_W = 4;
    localparam int CODE_W  = 2;
    localparam int COUNT_W = 8;
    localparam int WORD_W  = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_LEVEL    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_LEVEL       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_LEVEL    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_CODE        = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_CODE      = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_CODE       = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TICKS    = 8'd7;

    // reset values
    localparam logic [LEVEL_W-1:0] RST_REVERSE_LEVEL    = 4'd0;
    localparam logic [LEVEL_W-1:0] RST_STOP_LEVEL       = 4'd4;
    localparam logic [LEVEL_W-1:0] RST_FORWARD_LEVEL    = 4'd8;
    localparam logic [CODE_W-1:0]  RST_LEFT_CODE        = 2'd0;
    localparam logic [CODE_W-1:0]  RST_CENTER_CODE      = 2'd1;
    localparam logic [CODE_W-1:0]  RST_RIGHT_CODE       = 2'd2;
    localparam logic [COUNT_W-1:0] RST_LONG_PRESS_TICKS = 8'd10;
    localparam logic [COUNT_W-1:0] RST_RELEASE_TICKS    = 8'd5;

    // DAC word encoding
    localparam logic [WORD_W-1:0] SPEED_PREFIX = 16'h7000;
    localparam logic [WORD_W-1:0] TURN_PREFIX  = 16'hF000;
    localparam logic [WORD_W-1:0] SPEED_STEP   = 16'd496;
    localparam logic [WORD_W-1:0] TURN_STEP    = 16'd1984;
    localparam logic [WORD_W-1:0] WORD_OFFSET  = 16'd64;

    typedef struct packed {
        logic [LEVEL_W-1:0] reverse_level;
        logic [LEVEL_W-1:0] stop_level;
        logic [LEVEL_W-1:0] forward_level;
        logic [CODE_W-1:0]  left_code;
        logic [CODE_W-1:0]  center_code;
        logic [CODE_W-1:0]  right_code;
        logic [COUNT_W-1:0] long_press_ticks;
        logic [COUNT_W-1:0] release_ticks;
    } cfg_t;

    typedef struct packed {
        logic               send_speed;
        logic [WORD_W-1:0]  speed_word;
        logic               send_turn;
        logic [WORD_W-1:0]  turn_word;
        logic               long_sip_pin;
        logic               long_puff_pin;
    } result_t;

    function automatic logic [WORD_W-1:0] speed_word_f(input logic [LEVEL_W-1:0] level);
        logic [WORD_W-1:0] prod;
        prod = WORD_W'(level) * SPEED_STEP;
        return SPEED_PREFIX | (prod + WORD_OFFSET);
    endfunction

    function automatic logic [WORD_W-1:0] turn_word_f(input logic [CODE_W-1:0] code);
        logic [WORD_W-1:0] prod;
        prod = WORD_W'(code) * TURN_STEP;
        return TURN_PREFIX | (prod + WORD_OFFSET);
    endfunction

endpackage

`default_nettype wire

/* sv/sppci_cfg_regs.sv */
// ----------------------------------------------------------------------------
// sppci_cfg_regs
// Configuration register file, written one register per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sppci_cfg_regs
    import sppci_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_REVERSE_LEVEL:    cfg_next.reverse_level    = cfg_data[LEVEL_W-1:0];
                REG_STOP_LEVEL:       cfg_next.stop_level       = cfg_data[LEVEL_W-1:0];
                REG_FORWARD_LEVEL:    cfg_next.forward_level    = cfg_data[LEVEL_W-1:0];
                REG_LEFT_CODE:        cfg_next.left_code        = cfg_data[CODE_W-1:0];
                REG_CENTER_CODE:      cfg_next.center_code      = cfg_data[CODE_W-1:0];
                REG_RIGHT_CODE:       cfg_next.right_code       = cfg_data[CODE_W-1:0];
                REG_LONG_PRESS_TICKS: cfg_next.long_press_ticks = cfg_data[COUNT_W-1:0];
                REG_RELEASE_TICKS:    cfg_next.release_ticks    = cfg_data[COUNT_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reverse_level    <= RST_REVERSE_LEVEL;
            cfg_reg.stop_level       <= RST_STOP_LEVEL;
            cfg_reg.forward_level    <= RST_FORWARD_LEVEL;
            cfg_reg.left_code        <= RST_LEFT_CODE;
            cfg_reg.center_code      <= RST_CENTER_CODE;
            cfg_reg.right_code       <= RST_RIGHT_CODE;
            cfg_reg.long_press_ticks <= RST_LONG_PRESS_TICKS;
            cfg_reg.release_ticks    <= RST_RELEASE_TICKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* sv/sppci_engine.sv */
// ----------------------------------------------------------------------------
// sppci_engine
// Interpreter state and the per-tick sip rule followed by the puff rule.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sip_puff_command_interpreter_core_macros.svh"

module sppci_engine
    import sppci_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic fire,
    input  wire logic sip,
    input  wire logic puff,
    output result_t   res
);

    logic [COUNT_W-1:0] sip_count_reg,     sip_count_next;
    logic [COUNT_W-1:0] puff_count_reg,    puff_count_next;
    logic [COUNT_W-1:0] release_count_reg, release_count_next;
    logic [LEVEL_W-1:0] speed_level_reg,   speed_level_next;
    logic [CODE_W-1:0]  turn_state_reg,    turn_state_next;
    logic               sip_pin_reg,       sip_pin_next;
    logic               puff_pin_reg,      puff_pin_next;
    logic               send_speed;
    logic               send_turn;

    always_comb
    begin
        sip_count_next     = sip_count_reg;
        puff_count_next    = puff_count_reg;
        release_count_next = release_count_reg;
        speed_level_next   = speed_level_reg;
        turn_state_next    = turn_state_reg;
        sip_pin_next       = sip_pin_reg;
        puff_pin_next      = puff_pin_reg;
        send_speed         = 1'b0;
        send_turn          = 1'b0;

        // sip rule
        if (!sip)
        begin
            sip_pin_next = 1'b0;
            if (turn_state_next == cfg.right_code)
            begin
                sip_count_next     = '0;
                release_count_next = release_count_next + COUNT_W'(1);
                if (release_count_next == cfg.release_ticks)
                begin
                    turn_state_next    = cfg.center_code;
                    release_count_next = '0;
                    send_turn          = 1'b1;
                end
            end
            else if (sip_count_next != '0)
            begin
                speed_level_next = (speed_level_next <= cfg.stop_level) ?
                                   cfg.reverse_level : cfg.stop_level;
                sip_count_next   = '0;
                send_speed       = 1'b1;
            end
        end
        else
        begin
            sip_count_next = sip_count_next + COUNT_W'(1);
            if (sip_count_next == cfg.long_press_ticks)
            begin
                sip_pin_next    = 1'b1;
                turn_state_next = cfg.right_code;
                sip_count_next  = '0;
                send_turn       = 1'b1;
            end
        end

        // puff rule sees what the sip rule left
        if (!puff)
        begin
            puff_pin_next = 1'b0;
            if (turn_state_next == cfg.left_code)
            begin
                puff_count_next    = '0;
                release_count_next = release_count_next + COUNT_W'(1);
                if (release_count_next == cfg.release_ticks)
                begin
                    turn_state_next    = cfg.center_code;
                    release_count_next = '0;
                    send_turn          = 1'b1;
                end
            end
            else if (puff_count_next != '0)
            begin
                puff_count_next = '0;
                if (speed_level_next != cfg.forward_level)
                begin
                    if (speed_level_next == cfg.reverse_level)
                        speed_level_next = cfg.stop_level;
                    else
                        speed_level_next = speed_level_next + LEVEL_W'(1);
                    send_speed = 1'b1;
                end
            end
        end
        else
        begin
            puff_count_next = puff_count_next + COUNT_W'(1);
            if (puff_count_next == cfg.long_press_ticks)
            begin
                puff_pin_next   = 1'b1;
                turn_state_next = cfg.left_code;
                puff_count_next = '0;
                send_turn       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sip_count_reg     <= '0;
            puff_count_reg    <= '0;
            release_count_reg <= '0;
            speed_level_reg   <= RST_STOP_LEVEL;
            turn_state_reg    <= RST_CENTER_CODE;
            sip_pin_reg       <= 1'b0;
            puff_pin_reg      <= 1'b0;
        end
        else if (fire)
        begin
            sip_count_reg     <= sip_count_next;
            puff_count_reg    <= puff_count_next;
            release_count_reg <= release_count_next;
            speed_level_reg   <= speed_level_next;
            turn_state_reg    <= turn_state_next;
            sip_pin_reg       <= sip_pin_next;
            puff_pin_reg      <= puff_pin_next;
        end
    end

    always_comb
    begin
        res.send_speed    = send_speed;
        res.speed_word    = speed_word_f(speed_level_next);
        res.send_turn     = send_turn;
        res.turn_word     = turn_word_f(turn_state_next);
        res.long_sip_pin  = sip_pin_next;
        res.long_puff_pin = puff_pin_next;
    end

    `SPPCI_ASSERT_NEXT(a_sip_release_drops_pin, clk, rst_n, fire && !sip, !sip_pin_reg)
    `SPPCI_ASSERT_NEXT(a_puff_release_drops_pin, clk, rst_n, fire && !puff, !puff_pin_reg)
    `SPPCI_ASSERT_NEXT(a_state_holds_when_idle, clk, rst_n, !fire, $stable(speed_level_reg) && $stable(turn_state_reg) && $stable(release_count_reg))

endmodule

`default_nettype wire

/* sv/sip_puff_command_interpreter_core.sv */
// ----------------------------------------------------------------------------
// sip_puff_command_interpreter_core
// Sip/puff sensor interpreter: one sensor beat per timer tick in, one
// result beat with DAC words, send flags and long-press pins out.
// ----------------------------------------------------------------------------
// Takes one sample beat per clock and returns one result beat per sample,
// in order: the sample is captured in an input register, the sip and puff
// rules update the state in one combinational pass, and the result lands in
// the output register. Throughput is one beat per cycle as long as
// result_ready is high; when it drops while a result is held, sample_ready
// falls at once unless the input register is empty.
// cfg_ready is always high; write registers only while no beats are in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sip_puff_command_interpreter_core_macros.svh"

module sip_puff_command_interpreter_core
    import sppci_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  sample_valid,
    output logic                       sample_ready,
    input  wire logic                  sip_active,
    input  wire logic                  puff_active,

    output logic                       result_valid,
    input  wire logic                  result_ready,
    output logic                       send_speed,
    output logic [WORD_W-1:0]          speed_word,
    output logic                       send_turn,
    output logic [WORD_W-1:0]          turn_word,
    output logic                       long_sip_pin,
    output logic                       long_puff_pin
);

    cfg_t    cfg;
    result_t res;
    result_t res_reg;

    logic in_valid_reg;
    logic sip_reg;
    logic puff_reg;
    logic out_valid_reg;
    logic advance;
    logic fire;

    assign cfg_ready    = 1'b1;
    assign advance      = !out_valid_reg || result_ready;
    assign sample_ready = !in_valid_reg || advance;
    assign fire         = in_valid_reg && advance;

    sppci_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sppci_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (fire),
        .sip   (sip_reg),
        .puff  (puff_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_ready)
                in_valid_reg <= sample_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            sip_reg  <= sip_active;
            puff_reg <= puff_active;
        end
        if (fire)
            res_reg <= res;
    end

    assign result_valid  = out_valid_reg;
    assign send_speed    = res_reg.send_speed;
    assign speed_word    = res_reg.speed_word;
    assign send_turn     = res_reg.send_turn;
    assign turn_word     = res_reg.turn_word;
    assign long_sip_pin  = res_reg.long_sip_pin;
    assign long_puff_pin = res_reg.long_puff_pin;

    `SPPCI_ASSERT_NEXT(a_fire_gives_result, clk, rst_n, fire, out_valid_reg)
    `SPPCI_ASSERT_SAME(a_no_fire_when_stalled, clk, rst_n, out_valid_reg && !result_ready, !fire)
    `SPPCI_ASSERT_NEXT(a_stall_keeps_sample, clk, rst_n, in_valid_reg && !advance, in_valid_reg && $stable(sip_reg) && $stable(puff_reg))

endmodule

`default_nettype wire

/* verif/sppci_tick_checker.sv */
// ----------------------------------------------------------------------------
// sppci_tick_checker
// Watches the register, sample and result channels of the sip/puff command
// interpreter, predicts one result per accepted sample and compares each
// result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sppci_tick_checker
    import sppci_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  sample_valid,
    input  logic                  sample_ready,
    input  logic                  sip_active,
    input  logic                  puff_active,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  logic                  send_speed,
    input  logic [WORD_W-1:0]     speed_word,
    input  logic                  send_turn,
    input  logic [WORD_W-1:0]     turn_word,
    input  logic                  long_sip_pin,
    input  logic                  long_puff_pin,
    output int                    errors,
    output int                    outstanding,
    output int                    compared
);

    typedef enum logic [1:0] {RULE_QUIET, RULE_SPEED, RULE_TURN} rule_effect_t;

    cfg_t               regs;
    logic [COUNT_W-1:0] sip_held;
    logic [COUNT_W-1:0] puff_held;
    logic [COUNT_W-1:0] released;
    logic [LEVEL_W-1:0] speed_lvl;
    logic [CODE_W-1:0]  turn_code;
    logic               sip_pin;
    logic               puff_pin;
    result_t            predicted_results[$];

    task automatic flag(input string msg);
        if (errors < 30)
            $display("[%0t] MISMATCH beat %0d: %s", $time, compared, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
        if (got !== want)
            flag($sformatf("%s got 0x%04h expected 0x%04h", name, got, want));
    endtask

    // shared release counter, used by whichever rule owns the active turn
    function automatic rule_effect_t count_release();
        released = released + COUNT_W'(1);
        if (released == regs.release_ticks)
        begin
            turn_code = regs.center_code;
            released  = '0;
            return RULE_TURN;
        end
        return RULE_QUIET;
    endfunction

    function automatic rule_effect_t sip_rule(input logic active);
        if (!active)
        begin
            sip_pin = 1'b0;
            if (turn_code == regs.right_code)
            begin
                sip_held = '0;
                return count_release();
            end
            if (sip_held == '0)
                return RULE_QUIET;
            // short sip: stop, or full reverse when already at or below stop
            if (speed_lvl <= regs.stop_level)
                speed_lvl = regs.reverse_level;
            else
                speed_lvl = regs.stop_level;
            sip_held = '0;
            return RULE_SPEED;
        end
        sip_held = sip_held + COUNT_W'(1);
        if (sip_held == regs.long_press_ticks)
        begin
            sip_pin   = 1'b1;
            turn_code = regs.right_code;
            sip_held  = '0;
            return RULE_TURN;
        end
        return RULE_QUIET;
    endfunction

    function automatic rule_effect_t puff_rule(input logic active);
        if (!active)
        begin
            puff_pin = 1'b0;
            if (turn_code == regs.left_code)
            begin
                puff_held = '0;
                return count_release();
            end
            if (puff_held == '0)
                return RULE_QUIET;
            puff_held = '0;
            if (speed_lvl == regs.forward_level)
                return RULE_QUIET;
            if (speed_lvl == regs.reverse_level)
                speed_lvl = regs.stop_level;
            else
                speed_lvl = speed_lvl + LEVEL_W'(1);   // wraps past 15
            return RULE_SPEED;
        end
        puff_held = puff_held + COUNT_W'(1);
        if (puff_held == regs.long_press_ticks)
        begin
            puff_pin  = 1'b1;
            turn_code = regs.left_code;
            puff_held = '0;
            return RULE_TURN;
        end
        return RULE_QUIET;
    endfunction

    function automatic result_t interpret_tick(input logic sip, input logic puff);
        rule_effect_t by_sip;
        rule_effect_t by_puff;
        result_t      r;
        by_sip  = sip_rule(sip);
        by_puff = puff_rule(puff);
        r.send_speed    = (by_sip == RULE_SPEED) || (by_puff == RULE_SPEED);
        r.speed_word    = SPEED_PREFIX | (speed_lvl * SPEED_STEP + WORD_OFFSET);
        r.send_turn     = (by_sip == RULE_TURN) || (by_puff == RULE_TURN);
        r.turn_word     = TURN_PREFIX | (turn_code * TURN_STEP + WORD_OFFSET);
        r.long_sip_pin  = sip_pin;
        r.long_puff_pin = puff_pin;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            regs.reverse_level    = RST_REVERSE_LEVEL;
            regs.stop_level       = RST_STOP_LEVEL;
            regs.forward_level    = RST_FORWARD_LEVEL;
            regs.left_code        = RST_LEFT_CODE;
            regs.center_code      = RST_CENTER_CODE;
            regs.right_code       = RST_RIGHT_CODE;
            regs.long_press_ticks = RST_LONG_PRESS_TICKS;
            regs.release_ticks    = RST_RELEASE_TICKS;
            sip_held  = '0;
            puff_held = '0;
            released  = '0;
            speed_lvl = RST_STOP_LEVEL;
            turn_code = RST_CENTER_CODE;
            sip_pin   = 1'b0;
            puff_pin  = 1'b0;
            predicted_results.delete();
            outstanding = 0;
            errors      = 0;
            compared    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_REVERSE_LEVEL:    regs.reverse_level    = cfg_data[LEVEL_W-1:0];
                    REG_STOP_LEVEL:       regs.stop_level       = cfg_data[LEVEL_W-1:0];
                    REG_FORWARD_LEVEL:    regs.forward_level    = cfg_data[LEVEL_W-1:0];
                    REG_LEFT_CODE:        regs.left_code        = cfg_data[CODE_W-1:0];
                    REG_CENTER_CODE:      regs.center_code      = cfg_data[CODE_W-1:0];
                    REG_RIGHT_CODE:       regs.right_code       = cfg_data[CODE_W-1:0];
                    REG_LONG_PRESS_TICKS: regs.long_press_ticks = cfg_data[COUNT_W-1:0];
                    REG_RELEASE_TICKS:    regs.release_ticks    = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            // a result beat always belongs to an earlier sample, so pop first
            if (result_valid && result_ready)
            begin
                if (predicted_results.size() == 0)
                    flag("result beat with no sample outstanding");
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("send_speed", send_speed, want.send_speed);
                    check_field("speed_word", speed_word, want.speed_word);
                    check_field("send_turn", send_turn, want.send_turn);
                    check_field("turn_word", turn_word, want.turn_word);
                    check_field("long_sip_pin", long_sip_pin, want.long_sip_pin);
                    check_field("long_puff_pin", long_puff_pin, want.long_puff_pin);
                    compared++;
                end
            end
            if (sample_valid && sample_ready)
                predicted_results.push_back(interpret_tick(sip_active, puff_active));
            outstanding = predicted_results.size();
        end
    end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives sensor samples and register writes into the sip/puff command
// interpreter under random idling and back-pressure; the tick checker
// predicts and compares every result beat, and this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import sppci_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  sample_valid;
    logic                  sample_ready;
    logic                  sip_active;
    logic                  puff_active;
    logic                  result_valid;
    logic                  result_ready;
    logic                  send_speed;
    logic [WORD_W-1:0]     speed_word;
    logic                  send_turn;
    logic [WORD_W-1:0]     turn_word;
    logic                  long_sip_pin;
    logic                  long_puff_pin;

    bit jitter_on;
    int ticks_sent;
    int settings_used;
    int errors;
    int outstanding;
    int compared;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    sip_puff_command_interpreter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .sip_active    (sip_active),
        .puff_active   (puff_active),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .send_speed    (send_speed),
        .speed_word    (speed_word),
        .send_turn     (send_turn),
        .turn_word     (turn_word),
        .long_sip_pin  (long_sip_pin),
        .long_puff_pin (long_puff_pin)
    );

    sppci_tick_checker tick_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .sip_active    (sip_active),
        .puff_active   (puff_active),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .send_speed    (send_speed),
        .speed_word    (speed_word),
        .send_turn     (send_turn),
        .turn_word     (turn_word),
        .long_sip_pin  (long_sip_pin),
        .long_puff_pin (long_puff_pin),
        .errors        (errors),
        .outstanding   (outstanding),
        .compared      (compared)
    );

    // result side back-pressure
    always @(negedge clk)
        result_ready <= jitter_on ? ($urandom_range(99) >= 14) : 1'b1;

    initial
    begin
        #2_000_000;
        $display("TIMEOUT with %0d result beats still outstanding", outstanding);
        $display("TEST FAILED");
        $finish;
    end

    // all driving tasks are entered and left at a falling edge
    task automatic send_tick(input logic s, input logic p);
        while (jitter_on && $urandom_range(99) < 14)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sip_active   <= s;
        puff_active  <= p;
        do @(posedge clk); while (!sample_ready);
        @(negedge clk);
        ticks_sent++;
    endtask

    task automatic hold(input logic s, input logic p, input int n);
        repeat (n) send_tick(s, p);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // stop sending and wait until every predicted beat has come back
    task automatic settle();
        sample_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_settings(input logic [7:0] rev, input logic [7:0] stop,
                                 input logic [7:0] fwd, input logic [7:0] lc,
                                 input logic [7:0] cc, input logic [7:0] rc,
                                 input logic [7:0] lp, input logic [7:0] rel);
        settle();
        write_reg(REG_REVERSE_LEVEL, rev);
        write_reg(REG_STOP_LEVEL, stop);
        write_reg(REG_FORWARD_LEVEL, fwd);
        write_reg(REG_LEFT_CODE, lc);
        write_reg(REG_CENTER_CODE, cc);
        write_reg(REG_RIGHT_CODE, rc);
        write_reg(REG_LONG_PRESS_TICKS, lp);
        write_reg(REG_RELEASE_TICKS, rel);
        settings_used++;
    endtask

    // mostly well-formed presses with random lengths, some noise
    task automatic run_mix(input int budget, input int lp, input int rel);
        int start;
        int lp_eff;
        int rel_eff;
        int short_max;
        int pick;
        start     = ticks_sent;
        lp_eff    = (lp == 0) ? 256 : lp;
        rel_eff   = (rel == 0) ? 256 : rel;
        short_max = (lp_eff > 7) ? 6 : ((lp_eff > 1) ? lp_eff - 1 : 1);
        while (ticks_sent - start < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
            begin
                hold(1'b1, 1'b0, $urandom_range(1, short_max));
                hold(1'b0, 1'b0, $urandom_range(1, 3));
            end
            else if (pick < 40)
            begin
                hold(1'b0, 1'b1, $urandom_range(1, short_max));
                hold(1'b0, 1'b0, $urandom_range(1, 3));
            end
            else if (pick < 52)
            begin
                hold(1'b1, 1'b0, lp_eff + $urandom_range(0, 2));
                hold(1'b0, 1'b0, rel_eff + $urandom_range(0, 2));
            end
            else if (pick < 64)
            begin
                hold(1'b0, 1'b1, lp_eff + $urandom_range(0, 2));
                hold(1'b0, 1'b0, rel_eff + $urandom_range(0, 2));
            end
            else if (pick < 76)
            begin
                // tap the other sensor while a turn is held
                if ($urandom_range(1))
                begin
                    hold(1'b1, 1'b0, lp_eff);
                    hold(1'b0, 1'b1, $urandom_range(1, 3));
                end
                else
                begin
                    hold(1'b0, 1'b1, lp_eff);
                    hold(1'b1, 1'b0, $urandom_range(1, 3));
                end
                hold(1'b0, 1'b0, $urandom_range(1, rel_eff + 1));
            end
            else if (pick < 86)
            begin
                hold(1'b1, 1'b1, $urandom_range(1, lp_eff + 1));
                hold(1'b0, 1'b0, $urandom_range(1, rel_eff + 1));
            end
            else
                repeat ($urandom_range(1, 6))
                    send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin : stimulus
        int lp;
        int rel;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        sample_valid  = 1'b0;
        sip_active    = 1'b0;
        puff_active   = 1'b0;
        jitter_on     = 1'b0;
        ticks_sent    = 0;
        settings_used = 1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: short presses at every speed corner, long presses, release
        write_reg(REG_LONG_PRESS_TICKS, 8'd2);
        write_reg(REG_RELEASE_TICKS, 8'd2);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1); send_tick(1'b0, 1'b0);   // step up
        send_tick(1'b1, 1'b0); send_tick(1'b0, 1'b0);   // above stop -> stop
        send_tick(1'b1, 1'b0); send_tick(1'b0, 1'b0);   // at stop -> reverse
        send_tick(1'b1, 1'b0); send_tick(1'b0, 1'b0);   // reverse again
        send_tick(1'b0, 1'b1); send_tick(1'b0, 1'b0);   // reverse -> stop
        hold(1'b1, 1'b1, 2);                            // both long in one tick
        hold(1'b0, 1'b0, 2);                            // release to center
        hold(1'b1, 1'b0, 2);                            // long sip, turn right
        send_tick(1'b0, 1'b1);                          // puff during release
        send_tick(1'b0, 1'b0);

        jitter_on <= 1'b1;
        load_settings(8'd0, 8'd4, 8'd8, 8'd0, 8'd1, 8'd2, 8'd3, 8'd2);
        run_mix(70, 3, 2);

        // a long stretch with neither side idling
        jitter_on <= 1'b0;
        load_settings(8'd0, 8'd4, 8'd8, 8'd0, 8'd1, 8'd2, 8'd4, 8'd3);
        run_mix(70, 4, 3);
        jitter_on <= 1'b1;

        // forward below stop, so puffs wrap past the top level
        load_settings(8'd2, 8'd4, 8'd1, 8'd0, 8'd1, 8'd2, 8'd5, 8'd4);
        run_mix(60, 5, 4);

        // coinciding levels and codes; writes to unused indexes are ignored
        load_settings(8'd5, 8'd5, 8'd5, 8'd1, 8'd1, 8'd1, 8'd2, 8'd1);
        write_reg(8'd8, 8'h0F);
        write_reg(8'hFF, 8'h00);
        run_mix(50, 2, 1);

        // out-of-range levels and codes, shortest press and release
        load_settings(8'hFF, 8'hFE, 8'hFF, 8'h03, 8'hFF, 8'h02, 8'd1, 8'd1);
        run_mix(50, 1, 1);

        repeat (6)
        begin
            lp  = $urandom_range(1, 8);
            rel = $urandom_range(1, 8);
            load_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'(lp), 8'(rel));
            run_mix(30, lp, rel);
        end

        // zero counts fire only after the 8-bit counters wrap
        load_settings(8'd0, 8'd4, 8'd8, 8'd0, 8'd1, 8'd2, 8'd0, 8'd0);
        hold(1'b0, 1'b1, 256);
        hold(1'b0, 1'b0, 257);

        settle();
        repeat (8) @(posedge clk);

        $display("Sent %0d sensor ticks under %0d register settings, %0d result beats checked.",
                 ticks_sent, settings_used, compared);
        $display("Covered short and long presses, turn release, speed wrap, odd codes, wraps.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sip_puff_command_interpreter_core.f */
+incdir+sv
sv/sppci_pkg.sv
sv/sppci_cfg_regs.sv
sv/sppci_engine.sv
sv/sip_puff_command_interpreter_core.sv
verif/sppci_tick_checker.sv
verif/tb_top.sv
